// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the response line parser RTL.
// Each macro clocks on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the cycle after ante holds
`define RLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check cons in the same cycle that ante holds
`define RLP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rlp_pkg.sv =====
// Types, codes, position constants and helper functions of the response line parser.
// Used by rlp_core, rlp_out_reg, serial_response_line_parser_top and sim/tb.sv; no dependencies.
`timescale 1ns / 1ps

package rlp_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_START = 3'd1,
      ST_NON_DIGIT = 3'd2,
      ST_MALFORMED = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   // Kind of the second part of a line
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_TEMP    = 2'd1,
      KIND_MODE    = 2'd2,
      KIND_GENERIC = 2'd3
   } kind_type;

   // One decoded line
   typedef struct packed {
      logic [2:0]  precision;
      logic [17:0] second_number;
      logic [7:0]  second_letter;
      kind_type    second_kind;
      logic [9:0]  first_number;
      logic [7:0]  first_letter;
      status_type  status;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);
   localparam int unsigned RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // Line length limit (items per line before overflow)
   localparam logic [6:0] MAX_LINE = 7'd63;
   localparam logic [6:0] POS_SAT  = 7'd127;
   localparam logic [4:0] LEN_SAT  = 5'd31;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UNITF = 8'h46;
   localparam logic [7:0] CH_UNITC = 8'h43;

   // Content positions of the fields
   localparam logic [4:0] POS_START     = 5'd0;
   localparam logic [4:0] POS_TYPE      = 5'd1;
   localparam logic [4:0] POS_NUM1_LO   = 5'd2;
   localparam logic [4:0] POS_NUM1_HI   = 5'd4;
   localparam logic [4:0] POS_SECOND    = 5'd5;
   localparam logic [4:0] POS_GEN_LO    = 5'd6;
   localparam logic [4:0] POS_GEN_HI    = 5'd8;
   localparam logic [4:0] POS_MPFX_HI   = 5'd13;
   localparam logic [4:0] POS_MODE_LO   = 5'd14;
   localparam logic [4:0] POS_MODE_HI   = 5'd16;
   localparam logic [4:0] POS_TPFX_HI   = 5'd17;
   localparam logic [4:0] POS_FMT_LO    = 5'd18;
   localparam logic [4:0] POS_FMT_HI    = 5'd20;
   localparam logic [4:0] POS_HIGH_LO   = 5'd22;
   localparam logic [4:0] POS_HIGH_HI   = 5'd24;
   localparam logic [4:0] POS_LOW_LO    = 5'd26;
   localparam logic [4:0] POS_LOW_HI    = 5'd28;

   // Content lengths used when closing a line
   localparam logic [4:0] LEN_MIN       = 5'd2;
   localparam logic [4:0] LEN_NO_SECOND = 5'd5;
   localparam logic [4:0] LEN_MODE_MIN  = 5'd14;
   localparam logic [4:0] LEN_TEMP_MIN  = 5'd18;
   localparam logic [4:0] LEN_TEMP_ONE  = 5'd25;
   localparam logic [4:0] LEN_TEMP_TWO  = 5'd29;

   // Temperature format fields
   localparam logic [9:0] FMT_UNIT_MASK  = 10'h018;
   localparam logic [2:0] FMT_ONE_BYTE   = 3'd1;
   localparam logic [2:0] FMT_TWO_BYTES  = 3'd2;

   // Prefix match flag bits
   localparam int unsigned PFX_TEMP_A = 0;
   localparam int unsigned PFX_TEMP_B = 1;
   localparam int unsigned PFX_MODE   = 2;

   // Pending non-digit flag bits
   localparam int unsigned PEND_GENERIC = 0;
   localparam int unsigned PEND_MODE    = 1;
   localparam int unsigned PEND_FORMAT  = 2;
   localparam int unsigned PEND_VALUE   = 3;

   // Report prefixes, from content position 5 on (":049,005,001,", ":067,003,002,", ":064,003,")
   localparam logic [7:0] TEMP_PFX_A [13] = '{8'h3A, 8'h30, 8'h34, 8'h39, 8'h2C, 8'h30,
      8'h30, 8'h35, 8'h2C, 8'h30, 8'h30, 8'h31, 8'h2C};
   localparam logic [7:0] TEMP_PFX_B [13] = '{8'h3A, 8'h30, 8'h36, 8'h37, 8'h2C, 8'h30,
      8'h30, 8'h33, 8'h2C, 8'h30, 8'h30, 8'h32, 8'h2C};
   localparam logic [7:0] MODE_PFX [9] = '{8'h3A, 8'h30, 8'h36, 8'h34, 8'h2C, 8'h30,
      8'h30, 8'h33, 8'h2C};

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Accumulate one decimal digit; restart loads the digit alone
   function automatic logic [9:0] digit_acc(input logic [9:0] acc, input logic restart,
                                            input logic [7:0] c);
      logic [9:0] d;
      d = {6'd0, c[3:0]};
      if (restart) begin
         return d;
      end
      return (acc << 3) + (acc << 1) + d;
   endfunction

endpackage

// ===== rtl/serial_response_line_parser_top.sv =====
// Response line parser top level: request register, parse core and result register.
// Depends on rlp_pkg, rlp_core, rlp_out_reg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one character of an ASCII response line per request, with
// req_tlast on the last character, and returns one decoded result per line on
// the rsp_ channel. A new character is accepted every cycle; a line's result
// is presented once its last character has passed the request register, which
// feeds the parse core, and the core's decode has been captured by the result
// register. The result register lets the next line's characters
// keep flowing while a result waits to be taken. The input stalls only when a
// line's last character finds the previous result still held, and for as long
// as that result is not taken. Status 0 means the fields are valid; any other
// status zeroes them.

module serial_response_line_parser_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] ch
   input  logic                             req_tlast,  // line_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] status, [10:3] first_letter, [20:11] first_number, [22:21] second_kind,
   // [30:23] second_letter, [48:31] second_number, [51:49] precision, [55:52] zero
   output logic [rlp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_ch_ff;
   logic                in_last_ff;
   logic                accept;
   logic                advance;
   logic                out_free;
   rlp_pkg::result_type core_result;
   rlp_pkg::result_type out_result;

   // Move the held request into the core unless it ends a line and the result is blocked
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready  = !in_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rlp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ch      (in_ch_ff),
      .last    (in_last_ff),
      .result  (core_result)
   );

   rlp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_last_ff),
      .load_data (core_result),
      .take      (rsp_tready),
      .free      (out_free),
      .valid     (rsp_tvalid),
      .data      (out_result)
   );

   // Pack the result, first field lowest
   assign rsp_tdata = {{(rlp_pkg::RSP_DATA_W - rlp_pkg::RESULT_W){1'b0}}, out_result};

   `RLP_ASSERT_NEXT(a_line_gives_rsp, advance && in_last_ff, rsp_tvalid,
      "line end did not produce a response")
   `RLP_ASSERT_NEXT(a_last_waits, in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready,
      in_valid_ff, "line end dropped while result was held")
   `RLP_ASSERT_NEXT(a_rsp_held, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "waiting response changed or dropped")

endmodule

// ===== rtl/rlp_core.sv =====
// Per-line parse state and the decode of a finished line.
// Depends on rlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          ch,
   input  logic                last,
   output rlp_pkg::result_type result
);

   logic [6:0]          pos_ff, pos_in;
   logic [4:0]          len_ff, len_in;
   logic                term_ff, term_in;
   logic [7:0]          type_ff, type_in;
   logic [9:0]          first_ff, first_in;
   logic [2:0]          flags_ff, flags_in;
   logic [9:0]          fmt_ff, fmt_in;
   logic [9:0]          high_ff, high_in;
   logic [9:0]          low_ff, low_in;
   logic [7:0]          letter_ff, letter_in;
   rlp_pkg::status_type err_ff, err_in;
   logic [3:0]          pend_ff, pend_in;

   logic [4:0]          q;
   logic [3:0]          pidx;
   logic                dig;
   logic                temp_sel;

   // Advance the state by one character
   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      term_in   = term_ff;
      type_in   = type_ff;
      first_in  = first_ff;
      flags_in  = flags_ff;
      fmt_in    = fmt_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      letter_in = letter_ff;
      err_in    = err_ff;
      pend_in   = pend_ff;
      q         = len_ff;
      pidx      = 4'(len_ff - rlp_pkg::POS_SECOND);
      dig       = rlp_pkg::is_digit(ch);
      temp_sel  = flags_ff[rlp_pkg::PFX_TEMP_A] | flags_ff[rlp_pkg::PFX_TEMP_B];

      if (pos_ff >= rlp_pkg::MAX_LINE) begin
         err_in = rlp_pkg::ST_OVERFLOW;
      end
      if (pos_ff != rlp_pkg::POS_SAT) begin
         pos_in = pos_ff + 7'd1;
      end

      if (!term_ff) begin
         if (ch == rlp_pkg::CH_NUL) begin
            term_in = 1'b1;
         end else begin
            // start character, type letter, first number
            if (q == rlp_pkg::POS_START) begin
               if (ch != rlp_pkg::CH_LT && err_in == rlp_pkg::ST_OK) begin
                  err_in = rlp_pkg::ST_BAD_START;
               end
            end else if (q == rlp_pkg::POS_TYPE) begin
               if (ch < rlp_pkg::CH_A || ch > rlp_pkg::CH_Z) begin
                  if (err_in == rlp_pkg::ST_OK) begin
                     err_in = rlp_pkg::ST_BAD_START;
                  end
               end else begin
                  type_in = ch;
               end
            end else if (q <= rlp_pkg::POS_NUM1_HI) begin
               if (dig) begin
                  first_in = rlp_pkg::digit_acc(first_ff, q == rlp_pkg::POS_NUM1_LO, ch);
               end else if (err_in == rlp_pkg::ST_OK) begin
                  err_in = rlp_pkg::ST_NON_DIGIT;
               end
            end

            if (q == rlp_pkg::POS_SECOND) begin
               letter_in = ch;
            end

            // drop prefix candidates on mismatch
            if (q >= rlp_pkg::POS_SECOND && q <= rlp_pkg::POS_TPFX_HI) begin
               if (ch != rlp_pkg::TEMP_PFX_A[pidx]) begin
                  flags_in[rlp_pkg::PFX_TEMP_A] = 1'b0;
               end
               if (ch != rlp_pkg::TEMP_PFX_B[pidx]) begin
                  flags_in[rlp_pkg::PFX_TEMP_B] = 1'b0;
               end
               if (q <= rlp_pkg::POS_MPFX_HI) begin
                  if (ch != rlp_pkg::MODE_PFX[pidx]) begin
                     flags_in[rlp_pkg::PFX_MODE] = 1'b0;
                  end
               end
            end

            // generic number
            if (q >= rlp_pkg::POS_GEN_LO && q <= rlp_pkg::POS_GEN_HI) begin
               if (dig) begin
                  low_in = rlp_pkg::digit_acc(low_ff, q == rlp_pkg::POS_GEN_LO, ch);
               end else begin
                  pend_in[rlp_pkg::PEND_GENERIC] = 1'b1;
               end
            end

            // mode value
            if (q >= rlp_pkg::POS_MODE_LO && q <= rlp_pkg::POS_MODE_HI &&
                flags_ff[rlp_pkg::PFX_MODE]) begin
               if (dig) begin
                  high_in = rlp_pkg::digit_acc(high_ff, q == rlp_pkg::POS_MODE_LO, ch);
               end else begin
                  pend_in[rlp_pkg::PEND_MODE] = 1'b1;
               end
            end

            // temperature format and value bytes
            if (temp_sel) begin
               if (q >= rlp_pkg::POS_FMT_LO && q <= rlp_pkg::POS_FMT_HI) begin
                  if (dig) begin
                     fmt_in = rlp_pkg::digit_acc(fmt_ff, q == rlp_pkg::POS_FMT_LO, ch);
                  end else begin
                     pend_in[rlp_pkg::PEND_FORMAT] = 1'b1;
                  end
               end
               if (q >= rlp_pkg::POS_HIGH_LO && q <= rlp_pkg::POS_HIGH_HI) begin
                  if (dig) begin
                     high_in = rlp_pkg::digit_acc(high_ff, q == rlp_pkg::POS_HIGH_LO, ch);
                  end else begin
                     pend_in[rlp_pkg::PEND_VALUE] = 1'b1;
                  end
               end
               if (q >= rlp_pkg::POS_LOW_LO && q <= rlp_pkg::POS_LOW_HI &&
                   fmt_ff[2:0] == rlp_pkg::FMT_TWO_BYTES) begin
                  if (dig) begin
                     low_in = rlp_pkg::digit_acc(low_ff, q == rlp_pkg::POS_LOW_LO, ch);
                  end else begin
                     pend_in[rlp_pkg::PEND_VALUE] = 1'b1;
                  end
               end
            end

            if (len_ff != rlp_pkg::LEN_SAT) begin
               len_in = len_ff + 5'd1;
            end
         end
      end
   end

   // Decode the line from the updated state
   always_comb begin
      rlp_pkg::status_type st;
      rlp_pkg::kind_type   kind;
      logic [7:0]          let2;
      logic [17:0]         num;
      logic [2:0]          prec;
      logic [2:0]          bytes;
      logic [4:0]          need;

      st    = err_in;
      kind  = rlp_pkg::KIND_NONE;
      let2  = 8'd0;
      num   = 18'd0;
      prec  = 3'd0;
      bytes = fmt_in[2:0];
      need  = (bytes == rlp_pkg::FMT_TWO_BYTES) ? rlp_pkg::LEN_TEMP_TWO : rlp_pkg::LEN_TEMP_ONE;

      if (st == rlp_pkg::ST_OK && len_in < rlp_pkg::LEN_MIN) begin
         st = rlp_pkg::ST_BAD_START;
      end
      if (st == rlp_pkg::ST_OK && len_in > rlp_pkg::LEN_NO_SECOND) begin
         if ((flags_in[rlp_pkg::PFX_TEMP_A] || flags_in[rlp_pkg::PFX_TEMP_B]) &&
             len_in >= rlp_pkg::LEN_TEMP_MIN) begin
            if (pend_in[rlp_pkg::PEND_FORMAT]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else if ((bytes != rlp_pkg::FMT_ONE_BYTE && bytes != rlp_pkg::FMT_TWO_BYTES) ||
                         len_in < need) begin
               st = rlp_pkg::ST_MALFORMED;
            end else if (pend_in[rlp_pkg::PEND_VALUE]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               kind = rlp_pkg::KIND_TEMP;
               let2 = ((fmt_in & rlp_pkg::FMT_UNIT_MASK) != 10'd0) ?
                      rlp_pkg::CH_UNITF : rlp_pkg::CH_UNITC;
               prec = fmt_in[7:5];
               num  = (bytes == rlp_pkg::FMT_ONE_BYTE) ? {8'd0, high_in} :
                      ({high_in, 8'd0} | {8'd0, low_in});
            end
         end else if (flags_in[rlp_pkg::PFX_MODE] && len_in >= rlp_pkg::LEN_MODE_MIN) begin
            if (pend_in[rlp_pkg::PEND_MODE]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               kind = rlp_pkg::KIND_MODE;
               num  = {8'd0, high_in};
            end
         end else begin
            if (pend_in[rlp_pkg::PEND_GENERIC]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               kind = rlp_pkg::KIND_GENERIC;
               let2 = letter_in;
               num  = {8'd0, low_in};
            end
         end
      end

      result.status = st;
      if (st != rlp_pkg::ST_OK) begin
         result.first_letter  = 8'd0;
         result.first_number  = 10'd0;
         result.second_kind   = rlp_pkg::KIND_NONE;
         result.second_letter = 8'd0;
         result.second_number = 18'd0;
         result.precision     = 3'd0;
      end else begin
         result.first_letter  = type_in;
         result.first_number  = first_in;
         result.second_kind   = kind;
         result.second_letter = let2;
         result.second_number = num;
         result.precision     = prec;
      end
   end

   // Hold state between characters; clear it on reset and at the end of each line
   always_ff @(posedge clock) begin
      if (reset || (advance && last)) begin
         pos_ff    <= 7'd0;
         len_ff    <= 5'd0;
         term_ff   <= 1'b0;
         type_ff   <= 8'd0;
         first_ff  <= 10'd0;
         flags_ff  <= 3'b111;
         fmt_ff    <= 10'd0;
         high_ff   <= 10'd0;
         low_ff    <= 10'd0;
         letter_ff <= 8'd0;
         err_ff    <= rlp_pkg::ST_OK;
         pend_ff   <= 4'd0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         term_ff   <= term_in;
         type_ff   <= type_in;
         first_ff  <= first_in;
         flags_ff  <= flags_in;
         fmt_ff    <= fmt_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         letter_ff <= letter_in;
         err_ff    <= err_in;
         pend_ff   <= pend_in;
      end
   end

   `RLP_ASSERT_NEXT(a_line_clears, advance && last,
      pos_ff == 7'd0 && len_ff == 5'd0 && flags_ff == 3'b111 && err_ff == rlp_pkg::ST_OK,
      "parse state not cleared after line end")
   `RLP_ASSERT_NEXT(a_overflow_sticky, advance && !last && err_ff == rlp_pkg::ST_OVERFLOW,
      err_ff == rlp_pkg::ST_OVERFLOW, "overflow status lost within a line")
   `RLP_ASSERT_NEXT(a_nul_freezes_len, advance && !last && term_ff,
      term_ff && $stable(len_ff), "content length moved after NUL")

endmodule

// ===== rtl/rlp_out_reg.sv =====
// Result register of the response line parser: holds one decoded line until taken.
// Depends on rlp_pkg.
`timescale 1ns / 1ps

module rlp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rlp_pkg::result_type load_data,
   input  logic                take,
   output logic                free,
   output logic                valid,
   output rlp_pkg::result_type data
);

   logic                valid_ff, valid_in;
   rlp_pkg::result_type data_ff;

   // Room for a new result when empty or being taken now
   assign free     = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ===== sim/tb.sv =====
// Testbench for serial_response_line_parser_top: directed and random response lines.
// Predicts each decoded line itself and checks every result; needs rlp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_TARGET = 1390;

   // Report prefixes, first character in the top byte
   localparam logic [8*13-1:0] TEMP_A_TEXT = ":049,005,001,";
   localparam logic [8*13-1:0] TEMP_B_TEXT = ":067,003,002,";
   localparam logic [8*9-1:0]  MODE_TEXT   = ":064,003,";

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rlp_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // Line assembly and expected decoded lines
   logic [7:0] line_q[$];
   rlp_pkg::result_type decoded_lines_due[$];

   // Parser state of the prediction
   logic [6:0] line_pos;
   logic [7:0] type_ltr;
   logic [9:0] num1_acc;
   logic [2:0] pfx_live;
   logic [9:0] fmt_acc;
   logic [9:0] hi_acc;
   logic [9:0] lo_acc;
   logic [7:0] letter2;
   rlp_pkg::status_type err_code;
   logic [4:0] body_len;
   logic       nul_seen;
   logic [3:0] pend;

   // Run control and tallies
   bit steady_mode = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int mismatch_count = 0;
   int chars_sent = 0;
   int lines_sent = 0;
   int results_checked = 0;
   int temp_lines = 0;
   int mode_lines = 0;
   int generic_lines = 0;
   int error_lines = 0;

   serial_response_line_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= rlp_pkg::CH_ZERO && c <= rlp_pkg::CH_NINE;
   endfunction

   function automatic logic [9:0] next_acc(input logic [9:0] acc, input logic restart,
                                           input logic [7:0] c);
      logic [9:0] d;
      d = {2'b00, c} - 10'd48;
      if (restart) begin
         return d;
      end
      return acc * 10'd10 + d;
   endfunction

   task automatic clear_parser();
      line_pos = '0;
      type_ltr = '0;
      num1_acc = '0;
      pfx_live = 3'b111;
      fmt_acc  = '0;
      hi_acc   = '0;
      lo_acc   = '0;
      letter2  = '0;
      err_code = rlp_pkg::ST_OK;
      body_len = '0;
      nul_seen = 1'b0;
      pend     = '0;
   endtask

   task automatic flag_err(input rlp_pkg::status_type code);
      if (err_code == rlp_pkg::ST_OK) begin
         err_code = code;
      end
   endtask

   // Apply one content byte at content position q
   task automatic take_content(input int q, input logic [7:0] c);
      if (q == 0) begin
         if (c != rlp_pkg::CH_LT) flag_err(rlp_pkg::ST_BAD_START);
      end else if (q == 1) begin
         if (c < rlp_pkg::CH_A || c > rlp_pkg::CH_Z) flag_err(rlp_pkg::ST_BAD_START);
         else type_ltr = c;
      end else if (q <= 4) begin
         if (!is_dec(c)) flag_err(rlp_pkg::ST_NON_DIGIT);
         else num1_acc = next_acc(num1_acc, q == 2, c);
      end
      if (q == 5) begin
         letter2 = c;
      end
      // drop prefixes that no longer match
      if (q >= 5 && q <= 17) begin
         if (c != TEMP_A_TEXT[8*(17-q) +: 8]) pfx_live[rlp_pkg::PFX_TEMP_A] = 1'b0;
         if (c != TEMP_B_TEXT[8*(17-q) +: 8]) pfx_live[rlp_pkg::PFX_TEMP_B] = 1'b0;
         if (q <= 13 && c != MODE_TEXT[8*(13-q) +: 8]) pfx_live[rlp_pkg::PFX_MODE] = 1'b0;
      end
      if (q >= 6 && q <= 8) begin
         if (!is_dec(c)) pend[rlp_pkg::PEND_GENERIC] = 1'b1;
         else lo_acc = next_acc(lo_acc, q == 6, c);
      end
      if (q >= 14 && q <= 16 && pfx_live[rlp_pkg::PFX_MODE]) begin
         if (!is_dec(c)) pend[rlp_pkg::PEND_MODE] = 1'b1;
         else hi_acc = next_acc(hi_acc, q == 14, c);
      end
      if (pfx_live[rlp_pkg::PFX_TEMP_A] || pfx_live[rlp_pkg::PFX_TEMP_B]) begin
         if (q >= 18 && q <= 20) begin
            if (!is_dec(c)) pend[rlp_pkg::PEND_FORMAT] = 1'b1;
            else fmt_acc = next_acc(fmt_acc, q == 18, c);
         end
         if (q >= 22 && q <= 24) begin
            if (!is_dec(c)) pend[rlp_pkg::PEND_VALUE] = 1'b1;
            else hi_acc = next_acc(hi_acc, q == 22, c);
         end
         if (q >= 26 && q <= 28 && fmt_acc[2:0] == rlp_pkg::FMT_TWO_BYTES) begin
            if (!is_dec(c)) pend[rlp_pkg::PEND_VALUE] = 1'b1;
            else lo_acc = next_acc(lo_acc, q == 26, c);
         end
      end
   endtask

   // Advance the parser by one accepted character; queue the decoded line on its end
   task automatic parse_char(input logic [7:0] c, input logic is_last);
      rlp_pkg::result_type r;
      rlp_pkg::status_type st;
      int blen;
      int nbytes;
      logic [17:0] wide_hi;
      logic [17:0] wide_lo;
      if (line_pos >= rlp_pkg::MAX_LINE) begin
         err_code = rlp_pkg::ST_OVERFLOW;
      end
      if (line_pos != rlp_pkg::POS_SAT) begin
         line_pos = line_pos + 7'd1;
      end
      if (!nul_seen) begin
         if (c == rlp_pkg::CH_NUL) begin
            nul_seen = 1'b1;
         end else begin
            take_content(body_len, c);
            if (body_len != rlp_pkg::LEN_SAT) body_len = body_len + 5'd1;
         end
      end
      if (!is_last) begin
         return;
      end

      r = '0;
      st = err_code;
      blen = body_len;
      nbytes = fmt_acc[2:0];
      wide_hi = {8'd0, hi_acc};
      wide_lo = {8'd0, lo_acc};
      if (st == rlp_pkg::ST_OK && blen < 2) begin
         st = rlp_pkg::ST_BAD_START;
      end
      if (st == rlp_pkg::ST_OK && blen > 5) begin
         if ((pfx_live[rlp_pkg::PFX_TEMP_A] || pfx_live[rlp_pkg::PFX_TEMP_B]) && blen >= 18)
         begin
            if (pend[rlp_pkg::PEND_FORMAT]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else if (nbytes == 0 || nbytes > 2 || blen - 18 < 3 + 4 * nbytes) begin
               st = rlp_pkg::ST_MALFORMED;
            end else if (pend[rlp_pkg::PEND_VALUE]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               r.second_kind = rlp_pkg::KIND_TEMP;
               r.second_letter = ((fmt_acc & rlp_pkg::FMT_UNIT_MASK) != 0) ?
                                 rlp_pkg::CH_UNITF : rlp_pkg::CH_UNITC;
               r.precision = fmt_acc[7:5];
               r.second_number = (nbytes == 1) ? wide_hi : ((wide_hi << 8) | wide_lo);
            end
         end else if (pfx_live[rlp_pkg::PFX_MODE] && blen >= 14) begin
            if (pend[rlp_pkg::PEND_MODE]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               r.second_kind = rlp_pkg::KIND_MODE;
               r.second_number = wide_hi;
            end
         end else begin
            if (pend[rlp_pkg::PEND_GENERIC]) begin
               st = rlp_pkg::ST_NON_DIGIT;
            end else begin
               r.second_kind = rlp_pkg::KIND_GENERIC;
               r.second_letter = letter2;
               r.second_number = wide_lo;
            end
         end
      end

      if (st != rlp_pkg::ST_OK) begin
         r = '0;
         error_lines++;
      end else begin
         r.first_letter = type_ltr;
         r.first_number = num1_acc;
         case (r.second_kind)
            rlp_pkg::KIND_TEMP:    temp_lines++;
            rlp_pkg::KIND_MODE:    mode_lines++;
            rlp_pkg::KIND_GENERIC: generic_lines++;
            default: ;
         endcase
      end
      r.status = st;
      decoded_lines_due.push_back(r);
      clear_parser();
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_line(input rlp_pkg::result_type got,
                               input rlp_pkg::result_type want);
      if (got.status !== want.status)
         report_error($sformatf("result %0d status %0d, predicted %0d",
                                results_checked, got.status, want.status));
      if (got.first_letter !== want.first_letter)
         report_error($sformatf("result %0d first_letter %h, predicted %h",
                                results_checked, got.first_letter, want.first_letter));
      if (got.first_number !== want.first_number)
         report_error($sformatf("result %0d first_number %0d, predicted %0d",
                                results_checked, got.first_number, want.first_number));
      if (got.second_kind !== want.second_kind)
         report_error($sformatf("result %0d second_kind %0d, predicted %0d",
                                results_checked, got.second_kind, want.second_kind));
      if (got.second_letter !== want.second_letter)
         report_error($sformatf("result %0d second_letter %h, predicted %h",
                                results_checked, got.second_letter, want.second_letter));
      if (got.second_number !== want.second_number)
         report_error($sformatf("result %0d second_number %0d, predicted %0d",
                                results_checked, got.second_number, want.second_number));
      if (got.precision !== want.precision)
         report_error($sformatf("result %0d precision %0d, predicted %0d",
                                results_checked, got.precision, want.precision));
   endtask

   // Compare each accepted result with the oldest predicted line
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_lines_due.size() == 0) begin
            report_error("result arrived with no line pending");
         end else begin
            compare_line(rlp_pkg::result_type'(rsp_tdata[rlp_pkg::RESULT_W-1:0]),
                         decoded_lines_due.pop_front());
         end
         results_checked++;
      end
   end

   // Drive the result side: random backpressure or always ready in steady mode, long hold-offs on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else if (steady_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 38);
      end
   end

   // Abort when no handshake happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one character; entered and left at a falling edge
   task automatic send_char(input logic [7:0] c, input logic is_last);
      while (!steady_mode && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      parse_char(c, is_last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_q.size(); i++) begin
         send_char(line_q[i], i == line_q.size() - 1);
      end
      line_q.delete();
      lines_sent++;
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (decoded_lines_due.size() != 0) @(negedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_q.push_back(s[i]);
      end
   endtask

   // Append value as count decimal digits, zero padded
   task automatic add_digits(input int value, input int count);
      int scale;
      logic [7:0] d;
      scale = 1;
      for (int i = 1; i < count; i++) scale = scale * 10;
      for (int i = 0; i < count; i++) begin
         d = 8'((value / scale) % 10);
         line_q.push_back(rlp_pkg::CH_ZERO + d);
         scale = scale / 10;
      end
   endtask

   task automatic add_random_bytes(input int count);
      for (int i = 0; i < count; i++) begin
         line_q.push_back(8'($urandom_range(255)));
      end
   endtask

   // Build a mostly well-formed line, then maybe damage it
   task automatic build_random_line();
      int pick;
      int damage;
      int idx;
      int fmt;
      int nbytes;
      pick = $urandom_range(99);
      if (pick < 6) begin
         add_random_bytes($urandom_range(1, 40));
      end else begin
         line_q.push_back(rlp_pkg::CH_LT);
         if ($urandom_range(9) == 0) line_q.push_back(8'($urandom_range(255)));
         else line_q.push_back(rlp_pkg::CH_A + 8'($urandom_range(25)));
         if (pick < 22) begin
            // header only
            add_digits($urandom_range(999), $urandom_range(3));
         end else if (pick < 40) begin
            // generic letter and number
            add_digits($urandom_range(999), 3);
            line_q.push_back(8'($urandom_range(1, 255)));
            add_digits($urandom_range(999), $urandom_range(1, 3));
         end else if (pick < 58) begin
            add_digits($urandom_range(999), 3);
            add_text(string'(MODE_TEXT));
            add_digits($urandom_range(999), $urandom_range(1, 3));
         end else begin
            // temperature report, one or two value bytes
            add_digits($urandom_range(999), 3);
            if ($urandom_range(1)) add_text(string'(TEMP_A_TEXT));
            else add_text(string'(TEMP_B_TEXT));
            nbytes = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 2);
            fmt = ($urandom_range(7) << 5) | ($urandom_range(3) << 3) | nbytes;
            add_digits(fmt, 3);
            line_q.push_back(8'($urandom_range(255)));
            add_digits($urandom_range(999), 3);
            if (nbytes == 2 || $urandom_range(3) == 0) begin
               line_q.push_back(8'($urandom_range(255)));
               add_digits($urandom_range(999), 3);
            end
         end
      end

      damage = $urandom_range(99);
      if (damage < 12) begin
         idx = $urandom_range(line_q.size() - 1);
         line_q[idx] = 8'($urandom_range(255));
      end else if (damage < 20) begin
         idx = $urandom_range(1, line_q.size());
         while (line_q.size() > idx) void'(line_q.pop_back());
      end else if (damage < 23) begin
         idx = $urandom_range(64, 140);
         while (line_q.size() < idx) line_q.push_back(8'($urandom_range(255)));
      end else if (damage < 28) begin
         idx = $urandom_range(line_q.size() - 1);
         line_q[idx] = rlp_pkg::CH_NUL;
         add_random_bytes($urandom_range(3));
      end else if (damage < 36) begin
         add_random_bytes($urandom_range(1, 6));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Field extremes, every kind of line and every error
   task automatic test_directed_lines();
      add_text("<A");                          send_line();
      add_text("<");                           send_line();
      line_q.push_back(rlp_pkg::CH_NUL);       send_line();
      add_text("xZ123");                       send_line();
      add_text("<a12");                        send_line();
      add_text("<Z999");                       send_line();
      add_text("<B1x");                        send_line();
      add_text("<N000R255");                   send_line();
      add_text("<Q12345");                     send_line();
      add_text("<N001R2y5");                   send_line();
      add_text("<M002:064,003,005");           send_line();
      add_text("<M002:064,003,0k5");           send_line();
      add_text("<M002:064,003");               send_line();
      add_text("<T000:049,005,001,001,072");   send_line();
      add_text("<T999:067,003,002,250,999,999"); send_line();
      add_text("<T000:049,005,001,003,072");   send_line();
      add_text("<T000:067,003,002,002,072");   send_line();
      add_text("<T000:049,005,001,0a1,072");   send_line();
      add_text("<T000:049,005,001,001,0b2");   send_line();
      add_text("<T000:049,005,00");            send_line();
      // zero byte ends the content, the rest is ignored
      add_text("<A12");
      line_q.push_back(rlp_pkg::CH_NUL);
      add_text("zz9");
      send_line();
      // top bit set is not a digit
      add_text("<A");
      line_q.push_back(8'hB0);
      line_q.push_back(8'hFF);
      send_line();
      // exactly at the length limit, then one past it
      add_text("<A");
      line_q.push_back(rlp_pkg::CH_NUL);
      add_random_bytes(rlp_pkg::MAX_LINE - 3);
      send_line();
      add_text("<A");
      line_q.push_back(rlp_pkg::CH_NUL);
      add_random_bytes(rlp_pkg::MAX_LINE - 2);
      send_line();
      // saturate the item count
      for (int i = 0; i < 130; i++) line_q.push_back(8'hFF);
      send_line();
      wait_results_drained();
   endtask

   // No idling on either side
   task automatic test_back_to_back();
      steady_mode = 1'b1;
      for (int i = 0; i < 8; i++) begin
         build_random_line();
         send_line();
      end
      wait_results_drained();
      steady_mode = 1'b0;
   endtask

   // Hold off the result side while lines keep coming, so the input stalls
   task automatic test_receiver_hold();
      hold_requests = hold_requests + 1;
      @(negedge clock);
      for (int i = 0; i < 6; i++) begin
         add_text("<H042Z");
         add_digits($urandom_range(999), 3);
         send_line();
      end
      wait_results_drained();
   endtask

   task automatic test_random_lines();
      while (chars_sent < RANDOM_TARGET) begin
         build_random_line();
         send_line();
         if ($urandom_range(14) == 0) wait_results_drained();
      end
      wait_results_drained();
   endtask

   initial begin
      clear_parser();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_lines();
      test_back_to_back();
      test_receiver_hold();
      test_random_lines();
      test_receiver_hold();

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d characters in %0d lines; checked %0d decoded lines.",
               chars_sent, lines_sent, results_checked);
      $display("Lines decoded: %0d temperature, %0d mode, %0d generic, %0d with error status.",
               temp_lines, mode_lines, generic_lines, error_lines);
      if (mismatch_count == 0 && decoded_lines_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
